FILE: src/lpi_pkg.sv
// Shared types for the line point interpolator.
package lpi_pkg;

    // Per-item flags that travel alongside the divider data
    typedef struct packed {
        logic x_major;     // x is the major axis
        logic neg;         // minor delta is negative
        logic on_line;     // step lies within the line
        logic final_step;  // step is the last one
        logic len_zero;    // endpoints are equal
    } t_flags;

endpackage

FILE: src/line_point_interpolator.sv
// Top level of the line point interpolator: pixel coordinate at one step along a line.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | x_start y_start x_end y_end step_index
//  out     | from block| o_out_valid / i_out_stall| pixel_x pixel_y on_line final_step
//
// One item per cycle is taken and delivered while the output is not stalled; the
// pipeline is one stage for endpoint ordering, one for the step times minor-delta
// multiply, COORD_BITS stages of one-bit restoring division, and the output register.
// Reset clears the valid bits of every stage; payload registers are not reset.
// Each stage loads whenever it is empty or the stage after it loads, so bubbles
// close up under a stall and nothing is lost or repeated.
module line_point_interpolator #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COORD_BITS-1:0] i_step_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_on_line,
    output logic                  o_final_step
);
    import lpi_pkg::*;

    localparam int N = COORD_BITS;

    // ---------------- stage A: axis choice and endpoint ordering ----------------
    logic [N-1:0] w_adx;
    logic [N-1:0] w_ady;
    logic         w_xmaj;
    logic [N-1:0] w_maj0;
    logic [N-1:0] w_maj1;
    logic [N-1:0] w_min0;
    logic [N-1:0] w_min1;
    logic [N-1:0] w_lo_maj;
    logic [N-1:0] w_lo_min;
    logic [N-1:0] w_hi_min;

    logic         r_a_valid;
    logic         r_a_xmaj;
    logic         r_a_neg;
    logic [N-1:0] r_a_maj0;
    logic [N-1:0] r_a_min0;
    logic [N-1:0] r_a_len;
    logic [N-1:0] r_a_dmin;
    logic [N-1:0] r_a_s;

    // ---------------- stage B: multiply and flags ----------------
    logic [2*N-1:0] w_prod;
    t_flags         w_b_flags;

    // slot 0 is stage B, slots 1..N are the divider steps
    logic         w_valid [0:N];
    logic [N-1:0] w_rem   [0:N];
    logic [N-1:0] w_num   [0:N];
    logic [N-1:0] w_quo   [0:N];
    logic [N-1:0] w_div   [0:N];
    t_flags       w_flags [0:N];
    logic         w_ld    [0:N];

    logic         r_b_valid;
    logic [N-1:0] r_b_rem;
    logic [N-1:0] r_b_num;
    logic [N-1:0] r_b_len;
    t_flags       r_b_flags;

    // side payload that rides along with the divider
    logic [N-1:0] r_maj0 [0:N];
    logic [N-1:0] r_min0 [0:N];
    logic [N-1:0] r_s    [0:N];

    // ---------------- output stage ----------------
    logic         w_a_ld;
    logic         w_out_ld;
    logic [N-1:0] w_q;
    logic [N-1:0] w_majc;
    logic [N-1:0] w_minc;
    logic [N-1:0] n_px;
    logic [N-1:0] n_py;

    logic         r_out_valid;
    logic [N-1:0] r_px;
    logic [N-1:0] r_py;
    logic         r_on;
    logic         r_fin;

    // Load control: a slot loads when it is empty or its successor loads
    assign w_out_ld = !r_out_valid || !i_out_stall;
    assign w_a_ld   = !r_a_valid || w_ld[0];
    assign o_in_stall = !w_a_ld;

    genvar k;
    generate
        for (k = 0; k <= N; k++) begin : g_ld
            if (k == N) begin : g_last
                assign w_ld[k] = !w_valid[k] || w_out_ld;
            end else begin : g_mid
                assign w_ld[k] = !w_valid[k] || w_ld[k+1];
            end
        end
    endgenerate

    // Pick the major axis and order the endpoints so the major coordinate rises
    always_comb begin
        w_adx  = (i_x_end >= i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
        w_ady  = (i_y_end >= i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
        w_xmaj = (w_adx >= w_ady);
        w_maj0 = w_xmaj ? i_x_start : i_y_start;
        w_maj1 = w_xmaj ? i_x_end   : i_y_end;
        w_min0 = w_xmaj ? i_y_start : i_x_start;
        w_min1 = w_xmaj ? i_y_end   : i_x_end;
        if (w_maj1 < w_maj0) begin
            w_lo_maj = w_maj1;
            w_lo_min = w_min1;
            w_hi_min = w_min0;
        end else begin
            w_lo_maj = w_maj0;
            w_lo_min = w_min0;
            w_hi_min = w_min1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ld) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ld) begin
            r_a_xmaj <= w_xmaj;
            r_a_neg  <= (w_hi_min < w_lo_min);
            r_a_maj0 <= w_lo_maj;
            r_a_min0 <= w_lo_min;
            r_a_len  <= w_xmaj ? w_adx : w_ady;
            r_a_dmin <= w_xmaj ? w_ady : w_adx;
            r_a_s    <= i_step_index;
        end
    end

    // Form step times minor delta and the step flags
    always_comb begin
        w_prod               = {{N{1'b0}}, r_a_s} * {{N{1'b0}}, r_a_dmin};
        w_b_flags.x_major    = r_a_xmaj;
        w_b_flags.neg        = r_a_neg;
        w_b_flags.on_line    = (r_a_s <= r_a_len);
        w_b_flags.final_step = (r_a_s == r_a_len);
        w_b_flags.len_zero   = (r_a_len == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ld[0]) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_b_rem   <= w_prod[2*N-1:N];
            r_b_num   <= w_prod[N-1:0];
            r_b_len   <= r_a_len;
            r_b_flags <= w_b_flags;
            r_maj0[0] <= r_a_maj0;
            r_min0[0] <= r_a_min0;
            r_s[0]    <= r_a_s;
        end
    end

    assign w_valid[0] = r_b_valid;
    assign w_rem[0]   = r_b_rem;
    assign w_num[0]   = r_b_num;
    assign w_quo[0]   = '0;
    assign w_div[0]   = r_b_len;
    assign w_flags[0] = r_b_flags;

    // Divider: one quotient bit per stage, side payload alongside
    generate
        for (k = 0; k < N; k++) begin : g_div
            lpi_div_stage #(
                .W (N)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_ld[k+1]),
                .i_valid (w_valid[k]),
                .i_rem   (w_rem[k]),
                .i_num   (w_num[k]),
                .i_quo   (w_quo[k]),
                .i_div   (w_div[k]),
                .i_flags (w_flags[k]),
                .o_valid (w_valid[k+1]),
                .o_rem   (w_rem[k+1]),
                .o_num   (w_num[k+1]),
                .o_quo   (w_quo[k+1]),
                .o_div   (w_div[k+1]),
                .o_flags (w_flags[k+1])
            );

            always_ff @(posedge i_clk) begin
                if (w_ld[k+1]) begin
                    r_maj0[k+1] <= r_maj0[k];
                    r_min0[k+1] <= r_min0[k];
                    r_s[k+1]    <= r_s[k];
                end
            end
        end
    endgenerate

    // Compose the pixel; drop to zero when the step is off the line
    always_comb begin
        w_q    = w_flags[N].len_zero ? '0 : w_quo[N];
        w_majc = r_maj0[N] + r_s[N];
        w_minc = w_flags[N].neg ? (r_min0[N] - w_q) : (r_min0[N] + w_q);
        if (!w_flags[N].on_line) begin
            n_px = '0;
            n_py = '0;
        end else if (w_flags[N].x_major) begin
            n_px = w_majc;
            n_py = w_minc;
        end else begin
            n_px = w_minc;
            n_py = w_majc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= w_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_on  <= w_flags[N].on_line;
            r_fin <= w_flags[N].on_line && w_flags[N].final_step;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_on_line    = r_on;
    assign o_final_step = r_fin;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_valid && r_b_valid))
        else $error("input stalled while the front stages have room");

    a_final_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_step) |-> o_on_line)
        else $error("final step flagged off the line");

    a_off_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_on_line) |-> (o_pixel_x == '0 && o_pixel_y == '0))
        else $error("off-line item carries a non-zero pixel");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

FILE: src/lpi_div_stage.sv
// One registered restoring-division step of the interpolator's divider pipeline.
module lpi_div_stage #(
    parameter int W = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_valid,
    input  logic [W-1:0]    i_rem,
    input  logic [W-1:0]    i_num,
    input  logic [W-1:0]    i_quo,
    input  logic [W-1:0]    i_div,
    input  lpi_pkg::t_flags i_flags,
    output logic            o_valid,
    output logic [W-1:0]    o_rem,
    output logic [W-1:0]    o_num,
    output logic [W-1:0]    o_quo,
    output logic [W-1:0]    o_div,
    output lpi_pkg::t_flags o_flags
);
    import lpi_pkg::*;

    logic         r_valid;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_num;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_div;
    t_flags       r_flags;

    logic [W:0]   w_trial;
    logic [W:0]   w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        w_trial = {i_rem, i_num[W-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
    end

    // Hold the valid bit; clear it on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload when the slot is loaded
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem   <= n_rem;
            r_num   <= {i_num[W-2:0], 1'b0};
            r_quo   <= {i_quo[W-2:0], w_ge};
            r_div   <= i_div;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_flags = r_flags;

endmodule

FILE: verif/line_point_interpolator_tb.sv
// Self-checking testbench for the line point interpolator: random and directed line steps.
module line_point_interpolator_tb;

    localparam int COORD_BITS = 10;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int LATENCY    = COORD_BITS + 3;
    localparam int RANDOM_LINES = 1100;
    localparam int QUIET_TAIL   = 120;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        coord_t step_index;
    } line_item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   on_line;
        logic   final_step;
    } pixel_result_t;

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_in_valid   = 1'b0;
    logic   i_out_stall  = 1'b0;
    coord_t i_x_start    = '0;
    coord_t i_y_start    = '0;
    coord_t i_x_end      = '0;
    coord_t i_y_end      = '0;
    coord_t i_step_index = '0;
    logic   o_in_stall;
    logic   o_out_valid;
    coord_t o_pixel_x;
    coord_t o_pixel_y;
    logic   o_on_line;
    logic   o_final_step;

    line_item_t    pending_lines[$];
    pixel_result_t expected_pixels[$];
    line_item_t    driven_line;
    int            send_gap      = 0;
    int            stall_left    = 0;
    int            mismatch_count = 0;
    logic          quiet_tail    = 1'b0;

    line_point_interpolator #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_step_index (i_step_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_on_line    (o_on_line),
        .o_final_step (o_final_step)
    );

    always #6 i_clk = ~i_clk;

    // Length of the line along its major axis
    function automatic int line_length(line_item_t it);
        int dx;
        int dy;
        dx = int'(it.x_end) - int'(it.x_start);
        dy = int'(it.y_end) - int'(it.y_start);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx >= dy) ? dx : dy;
    endfunction

    // Pixel at the requested step, minor coordinate by truncating division
    function automatic pixel_result_t predict_pixel(line_item_t it);
        int maj0, maj1, min0, min1, len, s, tmp, majc, minc;
        bit x_major;
        pixel_result_t r;
        s   = int'(it.step_index);
        len = line_length(it);
        x_major = (len == ((int'(it.x_end) >= int'(it.x_start)) ?
                   int'(it.x_end) - int'(it.x_start) : int'(it.x_start) - int'(it.x_end)));
        if (x_major) begin
            maj0 = int'(it.x_start); maj1 = int'(it.x_end);
            min0 = int'(it.y_start); min1 = int'(it.y_end);
        end else begin
            maj0 = int'(it.y_start); maj1 = int'(it.y_end);
            min0 = int'(it.x_start); min1 = int'(it.x_end);
        end
        if (maj1 < maj0) begin
            tmp = maj0; maj0 = maj1; maj1 = tmp;
            tmp = min0; min0 = min1; min1 = tmp;
        end
        r = '0;
        if (s > len) return r;
        if (len == 0) begin
            r.pixel_x = it.x_start;
            r.pixel_y = it.y_start;
        end else begin
            majc = maj0 + s;
            minc = min0 + (s * (min1 - min0)) / len;
            r.pixel_x = x_major ? coord_t'(majc) : coord_t'(minc);
            r.pixel_y = x_major ? coord_t'(minc) : coord_t'(majc);
        end
        r.on_line    = 1'b1;
        r.final_step = (s == len);
        return r;
    endfunction

    function automatic line_item_t make_line(int xs, int ys, int xe, int ye, int st);
        line_item_t it;
        it.x_start    = coord_t'(xs);
        it.y_start    = coord_t'(ys);
        it.x_end      = coord_t'(xe);
        it.y_end      = coord_t'(ye);
        it.step_index = coord_t'(st);
        return it;
    endfunction

    // Driver: present pending items, hold them while stalled, log each accepted one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_pixels.push_back(predict_pixel(driven_line));
            end
            quiet_tail <= (pending_lines.size() < QUIET_TAIL);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_lines.size() > 0) begin
                    driven_line  = pending_lines.pop_front();
                    i_in_valid   <= 1'b1;
                    i_x_start    <= driven_line.x_start;
                    i_y_start    <= driven_line.y_start;
                    i_x_end      <= driven_line.x_end;
                    i_y_end      <= driven_line.y_end;
                    i_step_index <= driven_line.step_index;
                    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 18);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each delivered pixel against the oldest expectation, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d", o_pixel_x, o_pixel_y);
                    mismatch_count++;
                end else begin
                    pixel_result_t exp_px;
                    exp_px = expected_pixels.pop_front();
                    if (o_pixel_x !== exp_px.pixel_x) begin
                        $error("pixel_x: expected %0d, actual %0d", exp_px.pixel_x, o_pixel_x);
                        mismatch_count++;
                    end
                    if (o_pixel_y !== exp_px.pixel_y) begin
                        $error("pixel_y: expected %0d, actual %0d", exp_px.pixel_y, o_pixel_y);
                        mismatch_count++;
                    end
                    if (o_on_line !== exp_px.on_line) begin
                        $error("on_line: expected %0b, actual %0b", exp_px.on_line, o_on_line);
                        mismatch_count++;
                    end
                    if (o_final_step !== exp_px.final_step) begin
                        $error("final_step: expected %0b, actual %0b",
                               exp_px.final_step, o_final_step);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        line_item_t it;
        int mode, len, xs, ys;
        // equal endpoints: the single pixel, then a step beyond it
        pending_lines.push_back(make_line(0, 0, 0, 0, 0));
        pending_lines.push_back(make_line(0, 0, 0, 0, 5));
        pending_lines.push_back(make_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
        pending_lines.push_back(make_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                          COORD_MAX));
        // full-width horizontal and vertical lines
        pending_lines.push_back(make_line(0, 0, COORD_MAX, 0, 0));
        pending_lines.push_back(make_line(0, 0, COORD_MAX, 0, COORD_MAX));
        pending_lines.push_back(make_line(COORD_MAX, COORD_MAX, 0, COORD_MAX, 512));
        pending_lines.push_back(make_line(COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MAX));
        pending_lines.push_back(make_line(0, COORD_MAX, 0, 0, 1));
        // diagonal with equal deltas, endpoints reversed
        pending_lines.push_back(make_line(COORD_MAX, 0, 0, COORD_MAX, COORD_MAX));
        pending_lines.push_back(make_line(COORD_MAX, 0, 0, COORD_MAX, 700));
        pending_lines.push_back(make_line(0, COORD_MAX, COORD_MAX, 0, 333));
        // steep and shallow lines, most with falling minor coordinate, truncation toward zero
        pending_lines.push_back(make_line(500, 0, 0, COORD_MAX, 700));
        pending_lines.push_back(make_line(3, 900, 7, 100, 799));
        pending_lines.push_back(make_line(7, 100, 3, 900, 1));
        pending_lines.push_back(make_line(20, 15, 10, 10, 3));
        pending_lines.push_back(make_line(10, 10, 20, 7, 9));
        // steps at and beyond the line end
        pending_lines.push_back(make_line(10, 10, 20, 15, 11));
        pending_lines.push_back(make_line(10, 10, 20, 15, 10));
        pending_lines.push_back(make_line(100, 200, 101, 203, COORD_MAX));
        pending_lines.push_back(make_line(COORD_MAX, COORD_MAX, 0, 0, COORD_MAX));

        // random lines: mostly valid steps, some past the end
        for (int n = 0; n < RANDOM_LINES; n++) begin
            mode = $urandom_range(0, 9);
            xs = $urandom_range(0, COORD_MAX);
            ys = $urandom_range(0, COORD_MAX);
            if (mode == 0) begin
                it = make_line(xs, ys, xs, ys, $urandom_range(0, 2));
            end else if (mode <= 3) begin
                it = make_line(xs, ys, xs + $urandom_range(0, 40) - 20,
                               ys + $urandom_range(0, 40) - 20, 0);
            end else begin
                it = make_line(xs, ys, $urandom_range(0, COORD_MAX),
                               $urandom_range(0, COORD_MAX), 0);
            end
            if (mode != 0) begin
                len = line_length(it);
                case ($urandom_range(0, 9))
                    0:       it.step_index = coord_t'(len);
                    1, 2:    it.step_index = coord_t'($urandom_range(0, COORD_MAX));
                    3:       it.step_index = coord_t'((len < COORD_MAX) ? len + 1 : len);
                    default: it.step_index = coord_t'($urandom_range(0, len));
                endcase
            end
            pending_lines.push_back(it);
        end

        // hold reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain the input side, then the pipeline
        wait (pending_lines.size() == 0 && send_gap == 0);
        @(posedge i_clk);
        while (i_in_valid) @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 3) @(posedge i_clk);

        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("line_point_interpolator_tb: PASS");
        end else begin
            $display("line_point_interpolator_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("line_point_interpolator_tb: FAIL");
        $finish;
    end

endmodule
